>>> rtl/core/tvp_pkg.sv
// types, constants and codes shared by the velocity profiler modules
`default_nettype none

package tvp_pkg;

   localparam int TICK_RATE_HZ_DEF = 1000;

   localparam int DATA_W    = 32;
   localparam int SPD_W     = 31;
   localparam int OP_W      = 3;
   localparam int CSR_IDX_W = 3;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic signed [31:0] CRAWL_Q16  = 32'sd983040;
   localparam logic signed [32:0] FINISH_Q16 = 33'sd8192;
   localparam logic [31:0]        INV_ONE    = 32'h8000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_START  = 3'd1,
      OP_STOP   = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_ADJUST = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MOVE_DISTANCE = 3'd0,
      REG_TOP_SPEED     = 3'd1,
      REG_END_SPEED     = 3'd2,
      REG_ACCEL_RATE    = 3'd3,
      REG_INV_ACCEL     = 3'd4
   } csr_reg_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ACCEL = 2'd1,
      PH_BRAKE = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_START,
      DP_STOP,
      DP_CLEAR,
      DP_ADJUST,
      DP_TICK_BEGIN,
      DP_FSQ_MUL,
      DP_DV_MUL,
      DP_DV_LOAD,
      DP_DIFF,
      DP_HI_MUL,
      DP_LO_MUL,
      DP_SUM,
      DP_BRAKE,
      DP_SPEED,
      DP_STEP_MUL,
      DP_POS
   } dp_op_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_FSQ_MUL,
      CS_DV_MUL,
      CS_DV_LOAD,
      CS_DIFF,
      CS_HI_MUL,
      CS_LO_MUL,
      CS_SUM,
      CS_BRAKE,
      CS_SPEED,
      CS_STEP_MUL,
      CS_POS,
      CS_RESP
   } ctl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } dp_cmd_type;

endpackage

`default_nettype wire

>>> rtl/core/tvp_mult.sv
// shared registered unsigned multiplier
`default_nettype none

module tvp_mult (
   input  wire logic                        clock,
   input  wire logic [tvp_pkg::MUL_A_W-1:0] mul_a,
   input  wire logic [tvp_pkg::MUL_B_W-1:0] mul_b,
   output logic      [tvp_pkg::PROD_W-1:0]  prod
);
   import tvp_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

>>> rtl/core/tvp_datapath.sv
// profile state, config registers, arithmetic steps and result registers
`default_nettype none

module tvp_datapath #(
   parameter int TICK_RATE_HZ = tvp_pkg::TICK_RATE_HZ_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tvp_pkg::dp_cmd_type           cmd,
   input  wire logic                          csr_wr,
   input  wire logic [tvp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tvp_pkg::DATA_W-1:0]    csr_data,
   input  wire logic signed [31:0]            req_adjust_amount,
   output tvp_pkg::phase_type                 phase,
   output logic signed [31:0]                 rsp_speed_now,
   output logic signed [31:0]                 rsp_position_now,
   output logic signed [31:0]                 rsp_distance_left,
   output logic [1:0]                         rsp_phase_code,
   output logic                               rsp_done_flag
);
   import tvp_pkg::*;

   // exact floor(x / TICK_RATE_HZ) for x below 2^31 by one multiply and shift
   localparam int RATE_LOG  = $clog2(TICK_RATE_HZ);
   localparam int DIV_SHIFT = SPD_W + RATE_LOG;
   localparam logic [63:0] DIV_MULT_64 =
      ((64'd1 << DIV_SHIFT) + 64'(TICK_RATE_HZ) - 64'd1) / 64'(TICK_RATE_HZ);
   localparam logic [MUL_B_W-1:0] DIV_MULT = DIV_MULT_64[MUL_B_W-1:0];

   function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
      if (x[32] != x[31]) begin
         sat32 = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

   // config registers
   logic signed [31:0] md_ff, md_in;
   logic [30:0]        top_ff, top_in;
   logic [30:0]        endsp_ff, endsp_in;
   logic [30:0]        accel_ff, accel_in;
   logic [31:0]        inv_cfg_ff, inv_cfg_in;

   // profile state
   phase_type          phase_ff, phase_in;
   logic signed [31:0] speed_ff, speed_in;
   logic signed [31:0] position_ff, position_in;
   logic signed [31:0] target_ff, target_in;
   logic [31:0]        goal_ff, goal_in;
   logic               reverse_ff, reverse_in;
   logic [30:0]        fin_ff, fin_in;
   logic [31:0]        inv_ff, inv_in;
   logic [30:0]        dv_ff, dv_in;
   logic [61:0]        f2_ff, f2_in;

   // per-tick work registers
   logic signed [32:0] rem_ff, rem_in;
   logic [46:0]        d_ff, d_in;
   logic [62:0]        a_ff, a_in;
   logic [47:0]        r_ff, r_in;

   // result registers
   logic signed [31:0] rsp_speed_ff, rsp_speed_in;
   logic signed [31:0] rsp_pos_ff, rsp_pos_in;
   logic signed [31:0] rsp_dist_ff, rsp_dist_in;
   logic [1:0]         rsp_phase_ff, rsp_phase_in;
   logic               rsp_done_ff, rsp_done_in;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;

   logic [31:0]        speed_mag;
   logic [31:0]        pos_mag;
   logic signed [32:0] rem_now;
   logic [30:0]        fin_sel;
   logic signed [31:0] end_signed;
   logic signed [31:0] crawl_signed;
   logic [62:0]        v2;
   logic [62:0]        sq_diff;
   logic [79:0]        sum80;
   logic               brake_hit;
   logic [30:0]        quo;
   logic signed [31:0] step;
   logic signed [32:0] sp33, tg33, dv33, up33, dn33;
   logic signed [31:0] speed_next;

   tvp_mult u_mult (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   always_comb begin
      speed_mag    = speed_ff[31] ? 32'(-speed_ff) : 32'(speed_ff);
      pos_mag      = position_ff[31] ? 32'(-position_ff) : 32'(position_ff);
      rem_now      = $signed({1'b0, goal_ff}) - $signed({1'b0, pos_mag});
      fin_sel      = (endsp_ff > top_ff) ? top_ff : endsp_ff;
      end_signed   = reverse_ff ? -$signed({1'b0, fin_ff}) : $signed({1'b0, fin_ff});
      crawl_signed = reverse_ff ? -CRAWL_Q16 : CRAWL_Q16;
      v2           = prod[62:0];
      sq_diff      = (v2 >= {1'b0, f2_ff}) ? (v2 - {1'b0, f2_ff}) : ({1'b0, f2_ff} - v2);
      sum80        = {1'b0, a_ff, 16'd0} + {32'd0, prod[47:0]};
      brake_hit    = rem_ff[32] || ({16'd0, rem_ff[31:0]} < r_ff);
      quo          = 31'(prod >> DIV_SHIFT);
      step         = speed_ff[31] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      sp33         = {speed_ff[31], speed_ff};
      tg33         = {target_ff[31], target_ff};
      dv33         = $signed({2'b00, dv_ff});
      up33         = sp33 + dv33;
      dn33         = sp33 - dv33;
      if (speed_ff < target_ff) begin
         speed_next = (up33 > tg33) ? target_ff : up33[31:0];
      end else if (speed_ff > target_ff) begin
         speed_next = (dn33 < tg33) ? target_ff : dn33[31:0];
      end else begin
         speed_next = speed_ff;
      end
   end

   // config writes
   always_comb begin
      md_in      = md_ff;
      top_in     = top_ff;
      endsp_in   = endsp_ff;
      accel_in   = accel_ff;
      inv_cfg_in = inv_cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_MOVE_DISTANCE: md_in      = csr_data;
            REG_TOP_SPEED:     top_in     = csr_data[30:0];
            REG_END_SPEED:     endsp_in   = csr_data[30:0];
            REG_ACCEL_RATE:    accel_in   = csr_data[30:0];
            REG_INV_ACCEL:     inv_cfg_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // profile steps
   always_comb begin
      phase_in    = phase_ff;
      speed_in    = speed_ff;
      position_in = position_ff;
      target_in   = target_ff;
      goal_in     = goal_ff;
      reverse_in  = reverse_ff;
      fin_in      = fin_ff;
      inv_in      = inv_ff;
      dv_in       = dv_ff;
      f2_in       = f2_ff;
      rem_in      = rem_ff;
      d_in        = d_ff;
      a_in        = a_ff;
      r_in        = r_ff;
      mul_a       = '0;
      mul_b       = '0;
      case (cmd.op)
         DP_START: begin
            reverse_in  = md_ff[31];
            goal_in     = md_ff[31] ? (~md_ff + 32'd1) : md_ff;
            position_in = '0;
            speed_in    = '0;
            target_in   = md_ff[31] ? -$signed({1'b0, top_ff}) : $signed({1'b0, top_ff});
            fin_in      = fin_sel;
            inv_in      = (inv_cfg_ff > INV_ONE) ? INV_ONE : inv_cfg_ff;
            phase_in    = PH_ACCEL;
         end
         DP_FSQ_MUL: begin
            mul_a = MUL_A_W'(fin_ff);
            mul_b = MUL_B_W'(fin_ff);
         end
         DP_DV_MUL: begin
            f2_in = prod[61:0];
            mul_a = MUL_A_W'(accel_ff);
            mul_b = DIV_MULT;
         end
         DP_DV_LOAD: begin
            dv_in = quo;
         end
         DP_STOP: begin
            target_in = '0;
            speed_in  = '0;
            phase_in  = PH_DONE;
         end
         DP_CLEAR: begin
            position_in = '0;
            speed_in    = '0;
            target_in   = '0;
            phase_in    = PH_IDLE;
         end
         DP_ADJUST: begin
            position_in = sat32({position_ff[31], position_ff}
                                + {req_adjust_amount[31], req_adjust_amount});
         end
         DP_TICK_BEGIN: begin
            rem_in = rem_now;
            mul_a  = speed_mag;
            mul_b  = MUL_B_W'(speed_mag);
         end
         DP_DIFF: begin
            d_in = sq_diff[62:16];
         end
         DP_HI_MUL: begin
            mul_a = MUL_A_W'(d_ff[46:16]);
            mul_b = MUL_B_W'(inv_ff);
         end
         DP_LO_MUL: begin
            a_in  = prod[62:0];
            mul_a = MUL_A_W'(d_ff[15:0]);
            mul_b = MUL_B_W'(inv_ff);
         end
         DP_SUM: begin
            r_in = sum80[79:32];
         end
         DP_BRAKE: begin
            if (brake_hit) begin
               phase_in  = PH_BRAKE;
               target_in = (fin_ff == '0) ? crawl_signed : end_signed;
            end
         end
         DP_SPEED: begin
            speed_in = speed_next;
         end
         DP_STEP_MUL: begin
            mul_a = speed_mag;
            mul_b = DIV_MULT;
         end
         DP_POS: begin
            position_in = sat32({position_ff[31], position_ff} + {step[31], step});
            if (phase_ff != PH_DONE && rem_ff < FINISH_Q16) begin
               phase_in  = PH_DONE;
               target_in = end_signed;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_speed_in = rsp_speed_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_done_in  = rsp_done_ff;
      if (cmd.rsp_load) begin
         rsp_speed_in = speed_ff;
         rsp_pos_in   = position_ff;
         rsp_dist_in  = sat32(rem_now);
         rsp_phase_in = phase_ff;
         rsp_done_in  = (phase_ff == PH_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         md_ff       <= '0;
         top_ff      <= '0;
         endsp_ff    <= '0;
         accel_ff    <= '0;
         inv_cfg_ff  <= INV_ONE;
         phase_ff    <= PH_IDLE;
         speed_ff    <= '0;
         position_ff <= '0;
         target_ff   <= '0;
         goal_ff     <= '0;
         reverse_ff  <= 1'b0;
         fin_ff      <= '0;
      end else begin
         md_ff       <= md_in;
         top_ff      <= top_in;
         endsp_ff    <= endsp_in;
         accel_ff    <= accel_in;
         inv_cfg_ff  <= inv_cfg_in;
         phase_ff    <= phase_in;
         speed_ff    <= speed_in;
         position_ff <= position_in;
         target_ff   <= target_in;
         goal_ff     <= goal_in;
         reverse_ff  <= reverse_in;
         fin_ff      <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      inv_ff       <= inv_in;
      dv_ff        <= dv_in;
      f2_ff        <= f2_in;
      rem_ff       <= rem_in;
      d_ff         <= d_in;
      a_ff         <= a_in;
      r_ff         <= r_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign phase             = phase_ff;
   assign rsp_speed_now     = rsp_speed_ff;
   assign rsp_position_now  = rsp_pos_ff;
   assign rsp_distance_left = rsp_dist_ff;
   assign rsp_phase_code    = rsp_phase_ff;
   assign rsp_done_flag     = rsp_done_ff;

   // speed ramp never passes its target
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_SPEED && speed_ff <= target_ff) |=> speed_ff <= target_ff)
      else $error("speed overshot target while ramping up");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_SPEED && speed_ff >= target_ff) |=> speed_ff >= target_ff)
      else $error("speed overshot target while ramping down");

   // acceleration phase is entered only by a start
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ACCEL && $past(phase_ff) != PH_ACCEL) |-> $past(cmd.op) == DP_START)
      else $error("acceleration phase entered without start");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_POS && rem_ff < FINISH_Q16) |=> phase_ff == PH_DONE)
      else $error("move not finished inside finish window");

endmodule

`default_nettype wire

>>> rtl/core/tvp_ctrl.sv
// sequencer for the velocity profiler: operation decode, step order, result handoff
`default_nettype none

module tvp_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [tvp_pkg::OP_W-1:0] req_operation,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire tvp_pkg::phase_type       phase,
   output tvp_pkg::dp_cmd_type           cmd
);
   import tvp_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = DP_NOP;
      cmd.rsp_load = 1'b0;
      req_stall    = (state_ff != CS_IDLE);
      out_free     = !rsp_valid_ff || !rsp_stall;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = CS_RESP;
               case (req_operation)
                  OP_TICK: begin
                     if (phase != PH_IDLE) begin
                        cmd.op   = DP_TICK_BEGIN;
                        state_in = (phase == PH_ACCEL) ? CS_DIFF : CS_SPEED;
                     end
                  end
                  OP_START: begin
                     cmd.op   = DP_START;
                     state_in = CS_FSQ_MUL;
                  end
                  OP_STOP:   cmd.op = DP_STOP;
                  OP_CLEAR:  cmd.op = DP_CLEAR;
                  OP_ADJUST: cmd.op = DP_ADJUST;
                  default: begin
                  end
               endcase
            end
         end
         CS_FSQ_MUL: begin
            cmd.op   = DP_FSQ_MUL;
            state_in = CS_DV_MUL;
         end
         CS_DV_MUL: begin
            cmd.op   = DP_DV_MUL;
            state_in = CS_DV_LOAD;
         end
         CS_DV_LOAD: begin
            cmd.op   = DP_DV_LOAD;
            state_in = CS_RESP;
         end
         CS_DIFF: begin
            cmd.op   = DP_DIFF;
            state_in = CS_HI_MUL;
         end
         CS_HI_MUL: begin
            cmd.op   = DP_HI_MUL;
            state_in = CS_LO_MUL;
         end
         CS_LO_MUL: begin
            cmd.op   = DP_LO_MUL;
            state_in = CS_SUM;
         end
         CS_SUM: begin
            cmd.op   = DP_SUM;
            state_in = CS_BRAKE;
         end
         CS_BRAKE: begin
            cmd.op   = DP_BRAKE;
            state_in = CS_SPEED;
         end
         CS_SPEED: begin
            cmd.op   = DP_SPEED;
            state_in = CS_STEP_MUL;
         end
         CS_STEP_MUL: begin
            cmd.op   = DP_STEP_MUL;
            state_in = CS_POS;
         end
         CS_POS: begin
            cmd.op   = DP_POS;
            state_in = CS_RESP;
         end
         CS_RESP: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while previous result stalled");

   // braking check only follows a full braking-distance sum
   assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_BRAKE |-> $past(state_ff) == CS_SUM)
      else $error("brake decision without braking distance");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_DIFF |-> phase == PH_ACCEL)
      else $error("braking distance computed outside acceleration");

endmodule

`default_nettype wire

>>> rtl/core/trapezoidal_velocity_profiler.sv
// top level of the trapezoidal velocity profiler
//
//  channel  ports                                   handshake
//  request  req_operation, req_adjust_amount        req_valid / req_stall
//  result   rsp_speed_now, rsp_position_now,        rsp_valid / rsp_stall
//           rsp_distance_left, rsp_phase_code,
//           rsp_done_flag
//  config   csr_index, csr_data                     csr_valid / csr_ready
//
// one transaction at a time through a single shared multiplier
// tick while accelerating: braking distance steps, then speed, step mul and pos
// tick while braking or finished: speed, step mul, pos; start: fsq mul, dv mul, dv load
// each then loads its result; next request taken the cycle after its result is loaded
// a stalled result holds the block until it is taken
// synchronous reset clears the profile to idle and config to defaults
`default_nettype none

module trapezoidal_velocity_profiler #(
   parameter int TICK_RATE_HZ = tvp_pkg::TICK_RATE_HZ_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tvp_pkg::OP_W-1:0]      req_operation,
   input  wire logic signed [31:0]            req_adjust_amount,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [31:0]                 rsp_speed_now,
   output logic signed [31:0]                 rsp_position_now,
   output logic signed [31:0]                 rsp_distance_left,
   output logic [1:0]                         rsp_phase_code,
   output logic                               rsp_done_flag,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tvp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tvp_pkg::DATA_W-1:0]    csr_data
);
   import tvp_pkg::*;

   dp_cmd_type cmd;
   phase_type  phase;
   logic       csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   tvp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .phase         (phase),
      .cmd           (cmd)
   );

   tvp_datapath #(
      .TICK_RATE_HZ (TICK_RATE_HZ)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_wr            (csr_wr),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_adjust_amount (req_adjust_amount),
      .phase             (phase),
      .rsp_speed_now     (rsp_speed_now),
      .rsp_position_now  (rsp_position_now),
      .rsp_distance_left (rsp_distance_left),
      .rsp_phase_code    (rsp_phase_code),
      .rsp_done_flag     (rsp_done_flag)
   );

endmodule

`default_nettype wire

>>> tb/sv/trapezoidal_velocity_profiler_checker.sv
// result checker for the trapezoidal velocity profiler: predicts every result and compares
`timescale 1ns / 100ps

module trapezoidal_velocity_profiler_checker #(
   parameter int TICK_HZ = tvp_pkg::TICK_RATE_HZ_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [tvp_pkg::OP_W-1:0]      req_operation,
   input  logic signed [31:0]            req_adjust_amount,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [31:0]            rsp_speed_now,
   input  logic signed [31:0]            rsp_position_now,
   input  logic signed [31:0]            rsp_distance_left,
   input  logic [1:0]                    rsp_phase_code,
   input  logic                          rsp_done_flag,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [tvp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tvp_pkg::DATA_W-1:0]    csr_data,
   output int                            mismatches,
   output int                            outstanding
);
   import tvp_pkg::*;

   localparam longint POS_LIMIT    = 64'sh0000_0000_7FFF_FFFF;
   localparam longint NEG_LIMIT    = -64'sh0000_0000_8000_0000;
   localparam longint CRAWL_SPEED  = CRAWL_Q16;
   localparam longint FINISH_LEVEL = FINISH_Q16;

   typedef struct packed {
      logic [31:0] speed;
      logic [31:0] position;
      logic [31:0] dist_left;
      logic [1:0]  phase;
      logic        done;
   } profile_sample_type;

   profile_sample_type expected_samples[$];

   logic signed [31:0] cfg_distance;
   logic [30:0]        cfg_top;
   logic [30:0]        cfg_end;
   logic [30:0]        cfg_accel;
   logic [31:0]        cfg_inv;

   phase_type  pr_phase;
   longint     pr_speed;
   longint     pr_pos;
   longint     pr_target;
   longint     pr_end_signed;
   longint     pr_goal;
   logic       pr_reverse;
   longint     pr_accel;
   bit [63:0]  pr_inv;

   function automatic longint clamp32(longint x);
      if (x > POS_LIMIT) return POS_LIMIT;
      if (x < NEG_LIMIT) return NEG_LIMIT;
      return x;
   endfunction

   function automatic bit [63:0] magnitude(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint distance_to_go();
      return pr_goal - longint'(magnitude(pr_pos));
   endfunction

   function automatic longint braking_distance();
      bit [63:0] v, f, v2, f2, d, hi, lo, a, b;
      v  = magnitude(pr_speed);
      f  = magnitude(pr_end_signed);
      v2 = v * v;
      f2 = f * f;
      d  = ((v2 >= f2) ? v2 - f2 : f2 - v2) >> 16;
      hi = d >> 16;
      lo = d & 64'hFFFF;
      a  = hi * pr_inv;
      b  = lo * pr_inv;
      return longint'((a >> 16) + ((((a & 64'hFFFF) << 16) + b) >> 32));
   endfunction

   function automatic void reset_profile();
      cfg_distance  = '0;
      cfg_top       = '0;
      cfg_end       = '0;
      cfg_accel     = '0;
      cfg_inv       = INV_ONE;
      pr_phase      = PH_IDLE;
      pr_speed      = 0;
      pr_pos        = 0;
      pr_target     = 0;
      pr_end_signed = 0;
      pr_goal       = 0;
      pr_reverse    = 1'b0;
      pr_accel      = 0;
      pr_inv        = '0;
   endfunction

   function automatic void write_config(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
         REG_MOVE_DISTANCE: cfg_distance = data;
         REG_TOP_SPEED:     cfg_top      = data[30:0];
         REG_END_SPEED:     cfg_end      = data[30:0];
         REG_ACCEL_RATE:    cfg_accel    = data[30:0];
         REG_INV_ACCEL:     cfg_inv      = data;
         default: ;
      endcase
   endfunction

   function automatic void begin_move();
      logic [30:0] fin;
      fin           = (cfg_end > cfg_top) ? cfg_top : cfg_end;
      pr_reverse    = cfg_distance[31];
      pr_goal       = longint'(magnitude(longint'(cfg_distance)));
      pr_pos        = 0;
      pr_speed      = 0;
      pr_target     = pr_reverse ? -longint'(cfg_top) : longint'(cfg_top);
      pr_end_signed = pr_reverse ? -longint'(fin) : longint'(fin);
      pr_accel      = longint'(cfg_accel);
      pr_inv        = (cfg_inv > INV_ONE) ? INV_ONE : cfg_inv;
      pr_phase      = PH_ACCEL;
   endfunction

   function automatic void advance_tick();
      longint dv, rem;
      if (pr_phase == PH_IDLE) return;
      dv  = pr_accel / TICK_HZ;
      rem = distance_to_go();
      if (pr_phase == PH_ACCEL && rem < braking_distance()) begin
         pr_phase = PH_BRAKE;
         if (pr_end_signed == 0) begin
            pr_target = pr_reverse ? -CRAWL_SPEED : CRAWL_SPEED;
         end else begin
            pr_target = pr_end_signed;
         end
      end
      if (pr_speed < pr_target) begin
         pr_speed += dv;
         if (pr_speed > pr_target) pr_speed = pr_target;
      end else if (pr_speed > pr_target) begin
         pr_speed -= dv;
         if (pr_speed < pr_target) pr_speed = pr_target;
      end
      pr_pos = clamp32(pr_pos + pr_speed / TICK_HZ);
      if (pr_phase != PH_DONE && rem < FINISH_LEVEL) begin
         pr_phase  = PH_DONE;
         pr_target = pr_end_signed;
      end
   endfunction

   function automatic profile_sample_type apply_operation(logic [OP_W-1:0] op,
                                                          logic signed [31:0] adj);
      profile_sample_type s;
      longint             left;
      case (op)
         OP_TICK:   advance_tick();
         OP_START:  begin_move();
         OP_STOP: begin
            pr_target = 0;
            pr_speed  = 0;
            pr_phase  = PH_DONE;
         end
         OP_CLEAR: begin
            pr_pos    = 0;
            pr_speed  = 0;
            pr_target = 0;
            pr_phase  = PH_IDLE;
         end
         OP_ADJUST: pr_pos = clamp32(pr_pos + longint'(adj));
         default: ;
      endcase
      left        = clamp32(distance_to_go());
      s.speed     = pr_speed[31:0];
      s.position  = pr_pos[31:0];
      s.dist_left = left[31:0];
      s.phase     = pr_phase;
      s.done      = (pr_phase == PH_DONE);
      return s;
   endfunction

   function automatic void note_mismatch(string what, profile_sample_type want,
                                         profile_sample_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: exp spd=%h pos=%h left=%h ph=%0d done=%b", $time, what,
                  want.speed, want.position, want.dist_left, want.phase, want.done);
         $display("%0t %s: got spd=%h pos=%h left=%h ph=%0d done=%b", $time, what,
                  got.speed, got.position, got.dist_left, got.phase, got.done);
      end
   endfunction

   always @(posedge clock) begin
      profile_sample_type got, want;
      if (reset) begin
         reset_profile();
         expected_samples.delete();
         mismatches  = 0;
         outstanding = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.speed     = rsp_speed_now;
            got.position  = rsp_position_now;
            got.dist_left = rsp_distance_left;
            got.phase     = rsp_phase_code;
            got.done      = rsp_done_flag;
            if (expected_samples.size() == 0) begin
               note_mismatch("unexpected transaction", '0, got);
            end else begin
               want = expected_samples.pop_front();
               if (got.speed !== want.speed || got.position !== want.position ||
                   got.dist_left !== want.dist_left || got.phase !== want.phase ||
                   got.done !== want.done)
                  note_mismatch("mismatch", want, got);
            end
         end
         if (csr_valid && csr_ready) write_config(csr_index, csr_data);
         if (req_valid && !req_stall)
            expected_samples.push_back(apply_operation(req_operation, req_adjust_amount));
         outstanding = expected_samples.size();
      end
   end

endmodule

>>> tb/sv/trapezoidal_velocity_profiler_tb.sv
// testbench top for the trapezoidal velocity profiler: stimulus, flow control and verdict
`timescale 1ns / 100ps

module trapezoidal_velocity_profiler_tb;
   import tvp_pkg::*;

   localparam int TOTAL_ITEMS = 1800;
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic [OP_W-1:0]       req_operation     = OP_TICK;
   logic signed [31:0]    req_adjust_amount = '0;
   logic                  rsp_stall         = 1'b0;
   logic                  csr_valid         = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index         = REG_MOVE_DISTANCE;
   logic [DATA_W-1:0]     csr_data          = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   logic signed [31:0]    rsp_speed_now;
   logic signed [31:0]    rsp_position_now;
   logic signed [31:0]    rsp_distance_left;
   logic [1:0]            rsp_phase_code;
   logic                  rsp_done_flag;
   logic                  csr_ready;

   int mismatches;
   int outstanding;
   int sent_cnt = 0;

   trapezoidal_velocity_profiler uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_adjust_amount (req_adjust_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_speed_now     (rsp_speed_now),
      .rsp_position_now  (rsp_position_now),
      .rsp_distance_left (rsp_distance_left),
      .rsp_phase_code    (rsp_phase_code),
      .rsp_done_flag     (rsp_done_flag),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   trapezoidal_velocity_profiler_checker chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_adjust_amount (req_adjust_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_speed_now     (rsp_speed_now),
      .rsp_position_now  (rsp_position_now),
      .rsp_distance_left (rsp_distance_left),
      .rsp_phase_code    (rsp_phase_code),
      .rsp_done_flag     (rsp_done_flag),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit quiet_window();
      return sent_cnt >= 900 && sent_cnt < 1150;
   endfunction

   function automatic logic [31:0] q16_mm(int unsigned whole);
      return {whole[15:0], 16'($urandom_range(0, 65535))};
   endfunction

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_req(input logic [OP_W-1:0] op, input logic [31:0] adj);
      @(negedge clock);
      while (!quiet_window() && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_adjust_amount <= adj;
      do @(posedge clock); while (req_stall);
      if (op <= OP_ADJUST) sent_cnt++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_register(input csr_reg_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_move(input logic [31:0] move_len, input logic [31:0] top,
                            input logic [31:0] fin, input logic [31:0] acc,
                            input logic [31:0] inv);
      write_register(REG_MOVE_DISTANCE, move_len);
      write_register(REG_TOP_SPEED, top);
      write_register(REG_END_SPEED, fin);
      write_register(REG_ACCEL_RATE, acc);
      write_register(REG_INV_ACCEL, inv);
   endtask

   task automatic profile_step();
      int r;
      int small_adj;
      r = $urandom_range(0, 99);
      small_adj = $urandom_range(0, 131072) - 65536;
      if (r < 93) begin
         send_req(OP_TICK, $urandom);
      end else begin
         case (r)
            93, 94:  send_req(OP_ADJUST, small_adj);
            95:      send_req(OP_STOP, $urandom);
            96:      send_req(OP_CLEAR, $urandom);
            97:      send_req(OP_START, $urandom);
            98:      send_req(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), $urandom);
            default: send_req(OP_ADJUST, $urandom);
         endcase
      end
   endtask

   task automatic run_move();
      bit          wild;
      int          ticks;
      logic [31:0] move_len, top, fin, acc, inv;
      wild = ($urandom_range(0, 9) == 0);
      wait_idle();
      if (wild) begin
         move_len = pick32();
         top      = pick32();
         fin      = pick32();
         acc      = pick32();
         inv      = pick32();
      end else begin
         move_len = q16_mm($urandom_range(1, 40));
         if ($urandom_range(0, 1)) move_len = -move_len;
         top = ($urandom_range(0, 7) == 0) ? q16_mm($urandom_range(1, 14))
                                            : q16_mm($urandom_range(20, 1500));
         case ($urandom_range(0, 3))
            0, 1:    fin = '0;
            2:       fin = top / $urandom_range(2, 8);
            default: fin = top + q16_mm($urandom_range(0, 200));
         endcase
         acc = q16_mm($urandom_range(2000, 30000));
         inv = 32'(64'h0000_8000_0000_0000 / acc);
      end
      load_move(move_len, top, fin, acc, inv);
      if ($urandom_range(0, 9) != 0) send_req(OP_START, $urandom);
      ticks = wild ? $urandom_range(5, 40) : $urandom_range(40, 220);
      repeat (ticks) profile_step();
   endtask

   // receiver flow control with two long hold-offs
   initial begin
      int hold_left;
      int holds_done;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_done < 2 &&
             sent_cnt >= ((holds_done == 0) ? 400 : 1300)) begin
            hold_left = 250;
            holds_done++;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !quiet_window() && ($urandom_range(0, 99) < 7);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle corner cases and position saturation
      send_req(OP_TICK, '0);
      send_req(OP_UNUSED_FIRST, $urandom);
      send_req(OP_UNUSED_FIRST + 3'd1, $urandom);
      send_req(OP_UNUSED_LAST, $urandom);
      send_req(OP_ADJUST, 32'h7FFF_FFFF);
      send_req(OP_ADJUST, 32'h7FFF_FFFF);
      send_req(OP_ADJUST, 32'h8000_0000);
      send_req(OP_ADJUST, 32'h8000_0000);
      send_req(OP_STOP, '0);
      send_req(OP_TICK, '0);
      send_req(OP_CLEAR, '0);

      // extreme registers, end speed above top speed, oversized reciprocal
      wait_idle();
      load_move(32'h8000_0000, q16_mm(1000), 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_req(OP_START, '0);
      repeat (3) send_req(OP_TICK, '0);
      send_req(OP_ADJUST, 32'h7FFF_FFFF);
      send_req(OP_TICK, '0);
      send_req(OP_STOP, '0);
      send_req(OP_TICK, '0);
      send_req(OP_CLEAR, '0);

      // move shorter than the finish window, zero reciprocal
      wait_idle();
      load_move(32'd6553, 32'd327680, '0, 32'd65536000, '0);
      send_req(OP_START, '0);
      send_req(OP_TICK, '0);
      send_req(OP_TICK, '0);

      while (sent_cnt < TOTAL_ITEMS) run_move();

      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("** trapezoidal_velocity_profiler: PASSED **");
      end else begin
         $display("** trapezoidal_velocity_profiler: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** trapezoidal_velocity_profiler: FAILED **");
      $finish;
   end

endmodule
